// ===== hdl/lavm_pkg.sv =====
// Shared widths, types and constants for the look-at view matrix core.
package lavm_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CW   = 32;                // coordinate width
  localparam int UW   = FRAC_BITS + 2;     // unit vector component, signed
  localparam int VW   = CW + UW;           // raw vector component, signed
  localparam int MW   = VW - 1;            // raw magnitude
  localparam int PW   = $clog2(MW);        // leading-one position
  localparam int NMSB = 29;                // scaled magnitude msb position
  localparam int SW   = NMSB + 1;          // scaled magnitude width
  localparam int SQW  = 2 * SW;            // one square
  localparam int SUMW = SQW + 2;           // sum of three squares
  localparam int TW   = SUMW + 2;          // square root trial width
  localparam int LW   = SW + 1;            // vector length width
  localparam int QW   = FRAC_BITS + 1;     // quotient magnitude width
  localparam int NW   = SW + FRAC_BITS;    // dividend width
  localparam int DTW  = LW + QW;           // divide trial width
  localparam int SQ_ST = (LW + 1) / 2;     // square root stages, two bits each
  localparam int DV_ST = (QW + 1) / 2;     // divide stages, two bits each
  localparam int PUW  = 2 * UW;            // unit by unit product
  localparam int UUW  = PUW + 1 - FRAC_BITS; // true up component, signed
  localparam int PEW  = CW + UUW;          // eye by true up product
  localparam int DW   = PEW + 2;           // dot product width
  localparam int CIW  = 2;                 // column index width

  localparam logic [CIW-1:0] COL_LAST = 2'd3;

  localparam logic signed [CW-1:0] ONE     = CW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW - 1){1'b0}}};

  typedef logic [2:0][CW-1:0]  cvec_t;
  typedef logic [2:0][VW-1:0]  rvec_t;
  typedef logic [2:0][UW-1:0]  uvec_t;
  typedef logic [2:0][UUW-1:0] tvec_t;

  typedef struct packed {
    cvec_t eye;
    cvec_t aux;
  } side_t;

  typedef struct packed {
    uvec_t r;
    tvec_t u;
    uvec_t f;
    cvec_t t;
  } result_t;

endpackage

// ===== hdl/look_at_view_matrix_core.sv =====
// Top level of the look-at view matrix core: pipeline, cross products, serializer.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  eye, target and up vectors, Q16.16
//   out_     output     out_valid/out_stall column index, four rows, last mark
//
// New requests can enter while earlier ones are in flight. The serializer sends
// its four columns one per cycle while the output is not stalled, and holds one
// finished request while the next moves up. The first column leaves through 68
// pipeline registers, the serializer buffer and the output register.
// Reset (rst_n low, synchronous) clears valid bits and the column count, not data.
// Output stalls halt the pipeline only with the serializer full; nothing is dropped.
module look_at_view_matrix_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [lavm_pkg::CW-1:0] in_eye_x,
  input  logic signed [lavm_pkg::CW-1:0] in_eye_y,
  input  logic signed [lavm_pkg::CW-1:0] in_eye_z,
  input  logic signed [lavm_pkg::CW-1:0] in_target_x,
  input  logic signed [lavm_pkg::CW-1:0] in_target_y,
  input  logic signed [lavm_pkg::CW-1:0] in_target_z,
  input  logic signed [lavm_pkg::CW-1:0] in_up_x,
  input  logic signed [lavm_pkg::CW-1:0] in_up_y,
  input  logic signed [lavm_pkg::CW-1:0] in_up_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lavm_pkg::CIW-1:0]       out_column_index,
  output logic signed [lavm_pkg::CW-1:0] out_elem_row0,
  output logic signed [lavm_pkg::CW-1:0] out_elem_row1,
  output logic signed [lavm_pkg::CW-1:0] out_elem_row2,
  output logic signed [lavm_pkg::CW-1:0] out_elem_row3,
  output logic                           out_last_column
);
  import lavm_pkg::*;

  // negate a dot product, floor-shift it back to Q16.16 and saturate
  function automatic logic [CW-1:0] trans(input logic signed [DW-1:0] dot);
    logic signed [DW:0] nd;
    logic signed [DW:0] sh;
    nd = -((DW + 1)'(dot));
    sh = nd >>> FRAC_BITS;
    if (sh > (DW + 1)'(SAT_MAX)) return SAT_MAX;
    if (sh < (DW + 1)'(SAT_MIN)) return SAT_MIN;
    return sh[CW-1:0];
  endfunction

  logic en;
  logic ser_ready;

  // input register: forward difference and side data
  logic  v0_r;
  rvec_t d0_r;
  side_t s0_r;

  // forward vector out of the first normalizer
  logic  n1_v;
  uvec_t f1;
  side_t s1;

  // up cross forward: products, then differences
  logic                x1_v_r;
  logic [5:0][VW-1:0]  x1_p_r;
  uvec_t               x1_f_r;
  cvec_t               x1_eye_r;
  logic                x2_v_r;
  rvec_t               x2_c_r;
  side_t               x2_s_r;

  // right vector out of the second normalizer
  logic  n2_v;
  uvec_t r2;
  side_t s2;

  // true up and translation
  logic                y1_v_r;
  logic [5:0][PUW-1:0] y1_pu_r;
  logic [2:0][VW-1:0]  y1_pr_r, y1_pf_r;
  uvec_t               y1_r_r, y1_f_r;
  cvec_t               y1_eye_r;
  uvec_t               f2;

  logic                y2_v_r;
  tvec_t               y2_u_r, u_nxt;
  uvec_t               y2_r_r, y2_f_r;
  cvec_t               y2_eye_r;
  logic [DW-1:0]       y2_dr_r, y2_df_r;

  logic                y3_v_r;
  logic [2:0][PEW-1:0] y3_pe_r;
  tvec_t               y3_u_r;
  uvec_t               y3_r_r, y3_f_r;
  logic [DW-1:0]       y3_dr_r, y3_df_r;

  result_t             res;
  logic [DW-1:0]       du;

  // advance every stage together unless a finished request cannot leave
  assign en       = !y3_v_r || ser_ready;
  assign in_stall = !en;

  lavm_norm u_norm_f (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v0_r),
    .in_vec    (d0_r),
    .in_side   (s0_r),
    .out_valid (n1_v),
    .out_unit  (f1),
    .out_side  (s1)
  );

  lavm_norm u_norm_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x2_v_r),
    .in_vec    (x2_c_r),
    .in_side   (x2_s_r),
    .out_valid (n2_v),
    .out_unit  (r2),
    .out_side  (s2)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) f2[i] = s2.aux[i][UW-1:0];
  end

  always_comb begin
    logic signed [PUW:0] dif;
    for (int i = 0; i < 3; i++) begin
      dif = (PUW + 1)'($signed(y1_pu_r[2*i])) - (PUW + 1)'($signed(y1_pu_r[2*i+1]));
      dif = dif >>> FRAC_BITS;
      u_nxt[i] = dif[UUW-1:0];
    end
  end

  // final dot product and translation column feed the serializer directly
  assign du = DW'($signed(y3_pe_r[0])) + DW'($signed(y3_pe_r[1]))
            + DW'($signed(y3_pe_r[2]));

  always_comb begin
    res.r    = y3_r_r;
    res.u    = y3_u_r;
    res.f    = y3_f_r;
    res.t[0] = trans($signed(y3_dr_r));
    res.t[1] = trans($signed(du));
    res.t[2] = trans($signed(y3_df_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      x1_v_r <= 1'b0;
      x2_v_r <= 1'b0;
      y1_v_r <= 1'b0;
      y2_v_r <= 1'b0;
      y3_v_r <= 1'b0;
    end else if (en) begin
      v0_r   <= in_valid;
      x1_v_r <= n1_v;
      x2_v_r <= x1_v_r;
      y1_v_r <= n2_v;
      y2_v_r <= y1_v_r;
      y3_v_r <= y2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r[0]    <= VW'(in_eye_x) - VW'(in_target_x);
      d0_r[1]    <= VW'(in_eye_y) - VW'(in_target_y);
      d0_r[2]    <= VW'(in_eye_z) - VW'(in_target_z);
      s0_r.eye   <= {in_eye_z, in_eye_y, in_eye_x};
      s0_r.aux   <= {in_up_z, in_up_y, in_up_x};

      // up cross forward, exact
      x1_p_r[0]  <= VW'($signed(s1.aux[1])) * VW'($signed(f1[2]));
      x1_p_r[1]  <= VW'($signed(s1.aux[2])) * VW'($signed(f1[1]));
      x1_p_r[2]  <= VW'($signed(s1.aux[2])) * VW'($signed(f1[0]));
      x1_p_r[3]  <= VW'($signed(s1.aux[0])) * VW'($signed(f1[2]));
      x1_p_r[4]  <= VW'($signed(s1.aux[0])) * VW'($signed(f1[1]));
      x1_p_r[5]  <= VW'($signed(s1.aux[1])) * VW'($signed(f1[0]));
      x1_f_r     <= f1;
      x1_eye_r   <= s1.eye;
      for (int i = 0; i < 3; i++) begin
        x2_c_r[i]     <= x1_p_r[2*i] - x1_p_r[2*i+1];
        x2_s_r.aux[i] <= CW'($signed(x1_f_r[i]));
      end
      x2_s_r.eye <= x1_eye_r;

      // forward cross right, and eye products for two dot products
      y1_pu_r[0] <= PUW'($signed(f2[1])) * PUW'($signed(r2[2]));
      y1_pu_r[1] <= PUW'($signed(f2[2])) * PUW'($signed(r2[1]));
      y1_pu_r[2] <= PUW'($signed(f2[2])) * PUW'($signed(r2[0]));
      y1_pu_r[3] <= PUW'($signed(f2[0])) * PUW'($signed(r2[2]));
      y1_pu_r[4] <= PUW'($signed(f2[0])) * PUW'($signed(r2[1]));
      y1_pu_r[5] <= PUW'($signed(f2[1])) * PUW'($signed(r2[0]));
      for (int i = 0; i < 3; i++) begin
        y1_pr_r[i] <= VW'($signed(s2.eye[i])) * VW'($signed(r2[i]));
        y1_pf_r[i] <= VW'($signed(s2.eye[i])) * VW'($signed(f2[i]));
      end
      y1_r_r   <= r2;
      y1_f_r   <= f2;
      y1_eye_r <= s2.eye;

      y2_u_r   <= u_nxt;
      y2_r_r   <= y1_r_r;
      y2_f_r   <= y1_f_r;
      y2_eye_r <= y1_eye_r;
      y2_dr_r  <= DW'($signed(y1_pr_r[0])) + DW'($signed(y1_pr_r[1]))
                + DW'($signed(y1_pr_r[2]));
      y2_df_r  <= DW'($signed(y1_pf_r[0])) + DW'($signed(y1_pf_r[1]))
                + DW'($signed(y1_pf_r[2]));

      for (int i = 0; i < 3; i++) begin
        y3_pe_r[i] <= PEW'($signed(y2_eye_r[i])) * PEW'($signed(y2_u_r[i]));
      end
      y3_u_r  <= y2_u_r;
      y3_r_r  <= y2_r_r;
      y3_f_r  <= y2_f_r;
      y3_dr_r <= y2_dr_r;
      y3_df_r <= y2_df_r;
    end
  end

  lavm_ser u_ser (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (y3_v_r),
    .in_res           (res),
    .in_ready         (ser_ready),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_column_index (out_column_index),
    .out_elem_row0    (out_elem_row0),
    .out_elem_row1    (out_elem_row1),
    .out_elem_row2    (out_elem_row2),
    .out_elem_row3    (out_elem_row3),
    .out_last_column  (out_last_column)
  );

  // the last mark sits on the fourth column only
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_column == (out_column_index == COL_LAST)))
    else $error("last mark and column index disagree");

  // row 3 carries zero in rotation columns and one in the translation column
  a_row3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_column ? (out_elem_row3 == ONE) : (out_elem_row3 == '0)))
    else $error("bad row 3 element");

  // after a rotation column transfers, the next column follows at once
  a_col_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_column) |=>
      (out_valid && out_column_index == $past(out_column_index) + 2'd1))
    else $error("column sequence broken");

  // a finished request that cannot leave holds the input side
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (y3_v_r && !ser_ready) |-> in_stall)
    else $error("pipeline advanced over a waiting request");

endmodule

// ===== hdl/lavm_norm.sv =====
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
module lavm_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  lavm_pkg::rvec_t in_vec,
  input  lavm_pkg::side_t in_side,
  output logic            out_valid,
  output lavm_pkg::uvec_t out_unit,
  output lavm_pkg::side_t out_side
);
  import lavm_pkg::*;

  typedef struct packed {
    logic [2:0]         neg;
    logic               zero;
    logic [2:0][SW-1:0] sm;
    side_t              side;
  } carry_t;

  // magnitudes
  logic               v1_r;
  logic [2:0][MW-1:0] mag1_r, mag1_nxt;
  logic [2:0]         neg1_r, neg1_nxt;
  logic [MW-1:0]      or1_r;
  side_t              side1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg1_nxt[i] = in_vec[i][VW-1];
      mag1_nxt[i] = neg1_nxt[i] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
    end
  end

  // leading one of the largest magnitude
  logic               v2_r;
  logic [2:0][MW-1:0] mag2_r;
  logic [2:0]         neg2_r;
  logic [PW-1:0]      pos2_r, pos2_nxt;
  logic               zero2_r;
  side_t              side2_r;

  always_comb begin
    pos2_nxt = '0;
    for (int b = 0; b < MW; b++) begin
      if (or1_r[b]) pos2_nxt = PW'(b);
    end
  end

  // common shift into the window below 2^30
  logic   v3_r;
  carry_t c3_r, c3_nxt;

  always_comb begin
    logic [MW-1:0] sh;
    sh = '0;
    c3_nxt.neg  = neg2_r;
    c3_nxt.zero = zero2_r;
    c3_nxt.side = side2_r;
    for (int i = 0; i < 3; i++) begin
      if (pos2_r >= PW'(NMSB)) sh = mag2_r[i] >> (pos2_r - PW'(NMSB));
      else sh = mag2_r[i] << (PW'(NMSB) - pos2_r);
      c3_nxt.sm[i] = sh[SW-1:0];
    end
  end

  // squares, then their sum
  logic                v4_r;
  logic [2:0][SQW-1:0] sq4_r;
  carry_t              c4_r;
  logic                v5_r;
  logic [SUMW-1:0]     sum5_r;
  carry_t              c5_r;

  // square root, two result bits per stage
  logic [SQ_ST-1:0] sq_v_r;
  logic [SUMW-1:0]  sq_rem_r [SQ_ST];
  logic [SUMW-1:0]  sq_rem_nxt [SQ_ST];
  logic [LW-1:0]    sq_root_r [SQ_ST];
  logic [LW-1:0]    sq_root_nxt [SQ_ST];
  carry_t           sq_c_r [SQ_ST];

  for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
    logic [SUMW-1:0] rem_in;
    logic [LW-1:0]   root_in;
    if (k == 0) begin : g_head
      assign rem_in  = sum5_r;
      assign root_in = '0;
    end else begin : g_body
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
    end
    always_comb begin
      logic [TW-1:0]   trial;
      logic [SUMW-1:0] rem;
      logic [LW-1:0]   root;
      int              b;
      rem  = rem_in;
      root = root_in;
      for (int s = 0; s < 2; s++) begin
        b     = LW - 1 - 2 * k - s;
        trial = '0;
        if (b >= 0) begin
          trial = (TW'(root) << (b + 1)) + (TW'(1) << (2 * b));
          if (TW'(rem) >= trial) begin
            rem  = SUMW'(TW'(rem) - trial);
            root = root | (LW'(1) << b);
          end
        end
      end
      sq_rem_nxt[k]  = rem;
      sq_root_nxt[k] = root;
    end
  end

  // per-component divide by the length, two quotient bits per stage
  logic [DV_ST-1:0]    dv_v_r;
  logic [2:0][NW-1:0]  dv_rem_r [DV_ST];
  logic [2:0][NW-1:0]  dv_rem_nxt [DV_ST];
  logic [2:0][QW-1:0]  dv_q_r [DV_ST];
  logic [2:0][QW-1:0]  dv_q_nxt [DV_ST];
  logic [LW-1:0]       dv_len_r [DV_ST];
  carry_t              dv_c_r [DV_ST];

  for (genvar k = 0; k < DV_ST; k++) begin : g_div
    logic [2:0][NW-1:0] rem_in;
    logic [2:0][QW-1:0] q_in;
    logic [LW-1:0]      len_in;
    if (k == 0) begin : g_head
      always_comb begin
        for (int i = 0; i < 3; i++) rem_in[i] = NW'(sq_c_r[SQ_ST-1].sm[i]) << FRAC_BITS;
      end
      assign q_in   = '0;
      assign len_in = sq_root_r[SQ_ST-1];
    end else begin : g_body
      assign rem_in = dv_rem_r[k-1];
      assign q_in   = dv_q_r[k-1];
      assign len_in = dv_len_r[k-1];
    end
    always_comb begin
      logic [DTW-1:0]     trial;
      logic [2:0][NW-1:0] rem;
      logic [2:0][QW-1:0] q;
      int                 j;
      rem   = rem_in;
      q     = q_in;
      trial = '0;
      for (int s = 0; s < 2; s++) begin
        j = QW - 1 - 2 * k - s;
        if (j >= 0) begin
          trial = DTW'(len_in) << j;
          for (int i = 0; i < 3; i++) begin
            if (DTW'(rem[i]) >= trial) begin
              rem[i] = NW'(DTW'(rem[i]) - trial);
              q[i]   = q[i] | (QW'(1) << j);
            end
          end
        end
      end
      dv_rem_nxt[k] = rem;
      dv_q_nxt[k]   = q;
    end
  end

  // apply signs; an all-zero vector stays zero
  uvec_t  unit_nxt;
  logic   out_v_r;
  uvec_t  unit_r;
  side_t  side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_c_r[DV_ST-1].zero) unit_nxt[i] = '0;
      else if (dv_c_r[DV_ST-1].neg[i]) unit_nxt[i] = -(UW'(dv_q_r[DV_ST-1][i]));
      else unit_nxt[i] = UW'(dv_q_r[DV_ST-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      sq_v_r  <= '0;
      dv_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      sq_v_r  <= {sq_v_r[SQ_ST-2:0], v5_r};
      dv_v_r  <= {dv_v_r[DV_ST-2:0], sq_v_r[SQ_ST-1]};
      out_v_r <= dv_v_r[DV_ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= mag1_nxt;
      neg1_r  <= neg1_nxt;
      or1_r   <= mag1_nxt[0] | mag1_nxt[1] | mag1_nxt[2];
      side1_r <= in_side;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      pos2_r  <= pos2_nxt;
      zero2_r <= (or1_r == '0);
      side2_r <= side1_r;
      c3_r    <= c3_nxt;
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= SQW'(c3_r.sm[i]) * SQW'(c3_r.sm[i]);
      end
      c4_r   <= c3_r;
      sum5_r <= SUMW'(sq4_r[0]) + SUMW'(sq4_r[1]) + SUMW'(sq4_r[2]);
      c5_r   <= c4_r;
      sq_c_r[0] <= c5_r;
      for (int k = 0; k < SQ_ST; k++) begin
        sq_rem_r[k]  <= sq_rem_nxt[k];
        sq_root_r[k] <= sq_root_nxt[k];
      end
      for (int k = 1; k < SQ_ST; k++) sq_c_r[k] <= sq_c_r[k-1];
      dv_c_r[0]   <= sq_c_r[SQ_ST-1];
      dv_len_r[0] <= sq_root_r[SQ_ST-1];
      for (int k = 0; k < DV_ST; k++) begin
        dv_rem_r[k] <= dv_rem_nxt[k];
        dv_q_r[k]   <= dv_q_nxt[k];
      end
      for (int k = 1; k < DV_ST; k++) begin
        dv_c_r[k]   <= dv_c_r[k-1];
        dv_len_r[k] <= dv_len_r[k-1];
      end
      unit_r <= unit_nxt;
      side_r <= dv_c_r[DV_ST-1].side;
    end
  end

  assign out_valid = out_v_r;
  assign out_unit  = unit_r;
  assign out_side  = side_r;

endmodule

// ===== hdl/lavm_ser.sv =====
// Result buffer and column serializer with a registered output.
module lavm_ser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  lavm_pkg::result_t              in_res,
  output logic                           in_ready,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [lavm_pkg::CIW-1:0]       out_column_index,
  output logic signed [lavm_pkg::CW-1:0] out_elem_row0,
  output logic signed [lavm_pkg::CW-1:0] out_elem_row1,
  output logic signed [lavm_pkg::CW-1:0] out_elem_row2,
  output logic signed [lavm_pkg::CW-1:0] out_elem_row3,
  output logic                           out_last_column
);
  import lavm_pkg::*;

  logic           buf_v_r;
  result_t        res_r;
  logic [CIW-1:0] col_r;
  logic           ov_r;
  logic [CIW-1:0] oc_r;
  logic [CW-1:0]  o0_r, o1_r, o2_r, o3_r;
  logic           ol_r;
  logic           move, take;
  logic [CW-1:0]  e0, e1, e2, e3;
  logic           el;

  // move a column into the output register whenever it is free or drains
  assign move     = buf_v_r && (!ov_r || !out_stall);
  assign take     = move && (col_r == COL_LAST);
  assign in_ready = !buf_v_r || take;

  always_comb begin
    if (col_r == COL_LAST) begin
      e0 = res_r.t[0];
      e1 = res_r.t[1];
      e2 = res_r.t[2];
      e3 = ONE;
      el = 1'b1;
    end else begin
      e0 = CW'($signed(res_r.r[col_r]));
      e1 = CW'($signed(res_r.u[col_r]));
      e2 = CW'($signed(res_r.f[col_r]));
      e3 = '0;
      el = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      col_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        buf_v_r <= 1'b1;
        col_r   <= '0;
      end else begin
        if (take) buf_v_r <= 1'b0;
        if (move) col_r <= col_r + CIW'(1);
      end
      if (move) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) res_r <= in_res;
    if (move) begin
      oc_r <= col_r;
      o0_r <= e0;
      o1_r <= e1;
      o2_r <= e2;
      o3_r <= e3;
      ol_r <= el;
    end
  end

  assign out_valid        = ov_r;
  assign out_column_index = oc_r;
  assign out_elem_row0    = o0_r;
  assign out_elem_row1    = o1_r;
  assign out_elem_row2    = o2_r;
  assign out_elem_row3    = o3_r;
  assign out_last_column  = ol_r;

endmodule

// ===== verif/tb_look_at_view_matrix_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the look-at view matrix core with a fixed-point predictor.
module tb_look_at_view_matrix_core;
  import lavm_pkg::*;

  typedef struct {
    logic signed [CW-1:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
  } view_req_t;

  typedef struct {
    logic [CIW-1:0]       idx;
    logic signed [CW-1:0] row0, row1, row2, row3;
    logic                 last;
  } column_t;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic signed [CW-1:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic signed [CW-1:0] in_up_x = '0, in_up_y = '0, in_up_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CIW-1:0] out_column_index;
  logic signed [CW-1:0] out_elem_row0, out_elem_row1, out_elem_row2, out_elem_row3;
  logic out_last_column;

  view_req_t pending_q[$];   // requests waiting for the driver
  column_t   column_q[$];    // predicted columns, oldest first
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;         // long output hold-off, counted down by the monitor
  int n_errors = 0;
  int n_columns = 0;
  int n_requests = 0;
  int cycles = 0;

  look_at_view_matrix_core u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // Scale to a common exponent, take the length, divide each magnitude by it.
  // An all-zero vector stays zero.
  function automatic void normalize(input longint v[3], output longint o[3]);
    longint unsigned m[3], top, sum, len, q;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (top >= (64'd1 << 30)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << FRAC_BITS) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  // Negated dot product with the eye, floored back to Q16.16 and saturated.
  function automatic logic signed [CW-1:0] translation(input longint a[3], input longint e[3]);
    longint t;
    t = (-(a[0] * e[0] + a[1] * e[1] + a[2] * e[2])) >>> FRAC_BITS;
    if (t > longint'(SAT_MAX)) t = longint'(SAT_MAX);
    if (t < longint'(SAT_MIN)) t = longint'(SAT_MIN);
    return CW'(t);
  endfunction

  task automatic predict_columns(input view_req_t q);
    longint eye[3], tgt[3], up[3], d[3], f[3], c[3], r[3], u[3];
    column_t col;
    eye = '{q.ex, q.ey, q.ez};
    tgt = '{q.tx, q.ty, q.tz};
    up  = '{q.ux, q.uy, q.uz};
    for (int i = 0; i < 3; i++) d[i] = eye[i] - tgt[i];
    normalize(d, f);
    c[0] = up[1] * f[2] - up[2] * f[1];
    c[1] = up[2] * f[0] - up[0] * f[2];
    c[2] = up[0] * f[1] - up[1] * f[0];
    normalize(c, r);
    u[0] = (f[1] * r[2] - f[2] * r[1]) >>> FRAC_BITS;
    u[1] = (f[2] * r[0] - f[0] * r[2]) >>> FRAC_BITS;
    u[2] = (f[0] * r[1] - f[1] * r[0]) >>> FRAC_BITS;
    for (int k = 0; k < 3; k++) begin
      col.idx  = CIW'(k);
      col.row0 = CW'(r[k]);
      col.row1 = CW'(u[k]);
      col.row2 = CW'(f[k]);
      col.row3 = '0;
      col.last = 1'b0;
      column_q.push_back(col);
    end
    col.idx  = COL_LAST;
    col.row0 = translation(r, eye);
    col.row1 = translation(u, eye);
    col.row2 = translation(f, eye);
    col.row3 = ONE;
    col.last = 1'b1;
    column_q.push_back(col);
  endtask

  // ------------------------------------------------------------------- driver
  // Predict on each transfer, hold a stalled request, otherwise load the next
  // one unless the random idle draw says to skip this cycle.
  always @(posedge clk) begin
    view_req_t nx;
    logic nv;
    nv = in_valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_columns('{in_eye_x, in_eye_y, in_eye_z, in_target_x, in_target_y,
                          in_target_z, in_up_x, in_up_y, in_up_z});
        n_requests++;
      end
      nv = 1'b0;
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nx = pending_q.pop_front();
        nv = 1'b1;
        in_eye_x <= nx.ex;
        in_eye_y <= nx.ey;
        in_eye_z <= nx.ez;
        in_target_x <= nx.tx;
        in_target_y <= nx.ty;
        in_target_z <= nx.tz;
        in_up_x <= nx.ux;
        in_up_y <= nx.uy;
        in_up_z <= nx.uz;
      end
    end
    in_valid <= nv;
  end

  // ------------------------------------------------------------------ monitor
  task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                 input logic [CW-1:0] want);
    n_errors++;
    $display("mismatch column %0d %s: got %h want %h", n_columns, what, got, want);
  endtask

  always @(posedge clk) begin
    column_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (column_q.size() == 0) begin
        report_mismatch("unexpected transfer", CW'(out_column_index), '0);
      end else begin
        want = column_q.pop_front();
        if (out_column_index !== want.idx)
          report_mismatch("column_index", CW'(out_column_index), CW'(want.idx));
        if (out_elem_row0 !== want.row0) report_mismatch("elem_row0", out_elem_row0, want.row0);
        if (out_elem_row1 !== want.row1) report_mismatch("elem_row1", out_elem_row1, want.row1);
        if (out_elem_row2 !== want.row2) report_mismatch("elem_row2", out_elem_row2, want.row2);
        if (out_elem_row3 !== want.row3) report_mismatch("elem_row3", out_elem_row3, want.row3);
        if (out_last_column !== want.last)
          report_mismatch("last_column", CW'(out_last_column), CW'(want.last));
      end
      n_columns++;
    end
    // Hold off for the requested stretch, else stall at the phase's rate.
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
      2: case ($urandom_range(0, 4))
           0: return SAT_MIN;
           1: return SAT_MAX;
           2: return 0;
           3: return -1;
           default: return 1;
         endcase
      default: return (CW'($urandom_range(0, 200)) - 100) <<< FRAC_BITS;
    endcase
  endfunction

  function automatic view_req_t rand_request();
    view_req_t q;
    logic signed [CW-1:0] k;
    q = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    case ($urandom_range(0, 9))
      0: {q.tx, q.ty, q.tz} = {q.ex, q.ey, q.ez};        // eye on target
      1: {q.ux, q.uy, q.uz} = '0;                         // no up hint
      2: begin                                            // up along the view line
        k = $urandom_range(1, 7);
        q.ex = $signed($urandom_range(0, 2000)) - 1000;
        q.ey = $signed($urandom_range(0, 2000)) - 1000;
        q.ez = $signed($urandom_range(0, 2000)) - 1000;
        q.tx = 0; q.ty = 0; q.tz = 0;
        q.ux = q.ex * k; q.uy = q.ey * k; q.uz = q.ez * k;
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || column_q.size() != 0);
  endtask

  localparam logic signed [CW-1:0] ONE_Q = ONE;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: axis views, extremes, eye on target, degenerate up vectors,
    // saturating translation.
    pending_q.push_back('{0, 0, 5 * ONE_Q, 0, 0, 0, 0, ONE_Q, 0});
    pending_q.push_back('{ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 0, 0, 0, 0, ONE_Q, 0});
    pending_q.push_back('{SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN,
                          SAT_MIN, SAT_MAX, SAT_MIN});
    pending_q.push_back('{SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX,
                          SAT_MAX, SAT_MIN, SAT_MAX});
    pending_q.push_back('{SAT_MAX, SAT_MIN, SAT_MAX, 0, 0, 0, 0, ONE_Q, ONE_Q});
    pending_q.push_back('{SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, 0, ONE_Q, 0, 0});
    pending_q.push_back('{7, -3, 9, 7, -3, 9, 0, ONE_Q, 0});
    pending_q.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    pending_q.push_back('{0, 0, ONE_Q, 0, 0, 0, 0, 0, 0});
    pending_q.push_back('{0, 3 * ONE_Q, 0, 0, 0, 0, 0, ONE_Q, 0});
    pending_q.push_back('{-1, -1, -1, 0, 0, 0, 1, 0, 0});
    pending_q.push_back('{1, 0, 0, 0, 0, 0, -1, -1, -1});
    pending_q.push_back('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    pending_q.push_back('{SAT_MAX, 0, 0, SAT_MIN, 0, 0, 0, SAT_MIN, 0});
    wait_drained();

    // Random phases: free flowing, sparse sender, stalling receiver, both.
    // The first phase offers more requests than the pipe holds, so the
    // hold-off backs up the input while the sender keeps offering.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 64 : 34) : 0;
      stall_pct     = (ph == 2 || ph == 3) ? (ph == 2 ? 64 : 34) : 0;
      if (ph == 0) hold_left = 300;   // fill the pipe and back up the input
      for (int i = 0; i < (ph == 0 ? 90 : 40); i++) pending_q.push_back(rand_request());
      wait_drained();                 // sender pauses until all columns are back
    end
    send_idle_pct = 0;
    stall_pct = 0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d columns across four flow-control phases",
             n_requests, n_columns);
    $display("with a long output hold-off and %0d mismatches", n_errors);
    if (n_errors == 0 && column_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
